// ===== sv/wave_pkg.sv =====
// Shared types and constants of the windowed angle velocity estimator.
`default_nettype none
package wave_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA    = 2'd2;

	// Register widths and reset values.
	localparam int VEL_SCALE_W = 24;
	localparam int MAX_VEL_W   = 15;
	localparam int ALPHA_W     = 16;
	localparam int VEL_W       = 16;

	localparam logic [VEL_SCALE_W-1:0] VEL_SCALE_RST = 24'd2573;
	localparam logic [MAX_VEL_W-1:0]   MAX_VEL_RST   = 15'd15360;
	localparam logic [ALPHA_W-1:0]     ALPHA_RST     = 16'd6554;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL1,
		ST_SAT,
		ST_MUL2,
		ST_DONE
	} wave_state_t;

	// Datapath load strobes issued by the sequencer.
	typedef struct packed {
		logic ld_diff;
		logic ld_mul1;
		logic ld_sat;
		logic ld_mul2;
		logic upd;
	} wave_ctl_t;

endpackage
`default_nettype wire

// ===== sv/wave_ring.sv =====
// Angle ring memory: one write port, one registered read port.
`default_nettype none
module wave_ring #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/wave_dp.sv =====
// Velocity datapath: wrapped difference, scaling, limit check and exponential moving average.
`default_nettype none
module wave_dp #(
	parameter int ANGLE_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire wave_pkg::wave_ctl_t                 ctl,
	input  wire logic [ANGLE_BITS-1:0]               angle,
	input  wire logic [ANGLE_BITS-1:0]               oldest,
	input  wire logic [wave_pkg::VEL_SCALE_W-1:0]    vel_scale,
	input  wire logic [wave_pkg::MAX_VEL_W-1:0]      max_velocity,
	input  wire logic [wave_pkg::ALPHA_W-1:0]        ema_alpha,
	output logic signed [wave_pkg::VEL_W-1:0]        vel_next,
	output logic                                     rej
);
	import wave_pkg::*;

	localparam int RW = ANGLE_BITS + 2;           // raw difference width
	localparam int DW = ANGLE_BITS + 1;           // wrapped difference width
	localparam int PW = DW + VEL_SCALE_W + 1;     // scaled product width
	localparam int SW = PW + 1 - 16;              // product after the shift
	localparam logic signed [RW-1:0] HALF_TURN = RW'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [RW-1:0] FULL_TURN = RW'(2 ** ANGLE_BITS);
	localparam int EW = VEL_W + 1;                // EMA difference width
	localparam int QW = EW + ALPHA_W + 1;         // EMA product width

	logic signed [RW-1:0] raw_d;
	logic signed [RW-1:0] wrap_d;
	logic signed [DW-1:0] d_q;
	logic signed [PW-1:0] prod1_q;
	logic        [PW:0]   sum1;
	logic        [SW-1:0] sh1;
	logic signed [VEL_W-1:0] v_sat;
	logic        [VEL_W:0]   mag;
	logic signed [EW-1:0]    ema_diff;
	logic signed [EW-1:0]    ema_diff_q;
	logic                    rej_q;
	logic signed [QW-1:0]    prod2_q;
	logic signed [VEL_W-1:0] filt_q;

	// Difference to the oldest sample, folded into half a turn either way.
	always_comb begin
		raw_d = $signed({2'b00, angle}) - $signed({2'b00, oldest});
		if (raw_d > HALF_TURN) begin
			wrap_d = raw_d - FULL_TURN;
		end else if (raw_d < -HALF_TURN) begin
			wrap_d = raw_d + FULL_TURN;
		end else begin
			wrap_d = raw_d;
		end
	end

	// Round to nearest with ties upwards (add half, keep the upper bits), then saturate.
	always_comb begin
		sum1 = {prod1_q[PW-1], prod1_q} + (PW + 1)'(32768);
		sh1  = sum1[PW:16];
		if ((&sh1[SW-1:VEL_W-1]) || !(|sh1[SW-1:VEL_W-1])) begin
			v_sat = $signed(sh1[VEL_W-1:0]);
		end else if (sh1[SW-1]) begin
			v_sat = $signed({1'b1, {(VEL_W-1){1'b0}}});
		end else begin
			v_sat = $signed({1'b0, {(VEL_W-1){1'b1}}});
		end
		mag      = v_sat[VEL_W-1] ? ((VEL_W + 1)'(0) - {v_sat[VEL_W-1], v_sat})
		                          : {1'b0, v_sat};
		ema_diff = $signed({v_sat[VEL_W-1], v_sat}) - $signed({filt_q[VEL_W-1], filt_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_diff) begin
			d_q <= wrap_d[DW-1:0];
		end
		if (ctl.ld_mul1) begin
			prod1_q <= d_q * $signed({1'b0, vel_scale});
		end
		if (ctl.ld_sat) begin
			ema_diff_q <= ema_diff;
			rej_q      <= mag > {2'b00, max_velocity};
		end
		if (ctl.ld_mul2) begin
			prod2_q <= ema_diff_q * $signed({1'b0, ema_alpha});
		end
	end

	// The step lies between the held value and the new one, so 16 bits suffice.
	assign vel_next = rej_q ? filt_q : (filt_q + $signed(prod2_q[16 +: VEL_W]));
	assign rej      = rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctl.upd) begin
			filt_q <= vel_next;
		end
	end

endmodule
`default_nettype wire

// ===== sv/windowed_angle_velocity_estimator.sv =====
// Top level of the windowed angle velocity estimator: sequencer, registers and result stage.
//
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_stall    | angle_code
//  result   | out_valid / out_stall  | velocity, ready_res, rejected
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An angle beat that computes a velocity passes through the ring read at acceptance, the
// difference, the scaling multiply, rounding and limit check, the smoothing multiply, and the
// filter update as the result register loads. A filling beat goes straight to that last step.
// A finished result waits in the output register, so the next beat is taken meanwhile; only
// a second finished result holds the sequencer in its last state until out_stall drops.
// Reset restores the pointer, fill flag, filter and registers; ring contents need no clearing.
`default_nettype none
module windowed_angle_velocity_estimator #(
	parameter int WINDOW     = 8,
	parameter int ANGLE_BITS = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ANGLE_BITS-1:0]             angle_code,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [wave_pkg::VEL_W-1:0]      velocity,
	output logic                                   ready_res,
	output logic                                   rejected,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [wave_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wave_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wave_pkg::*;

	localparam int PTR_W = $clog2(WINDOW);

	wave_state_t state_q, state_d;
	wave_ctl_t   ctl;

	logic [VEL_SCALE_W-1:0] vel_scale_q;
	logic [MAX_VEL_W-1:0]   max_velocity_q;
	logic [ALPHA_W-1:0]     ema_alpha_q;

	logic [PTR_W-1:0]      ptr_q;
	logic [PTR_W-1:0]      ptr_inc;
	logic                  full_q;
	logic                  fill_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] oldest;

	logic                  in_acc;
	logic                  out_free;
	logic                  load_out;
	logic                  ptr_adv;
	logic                  wr_en;
	logic [ANGLE_BITS-1:0] wr_data;

	logic signed [VEL_W-1:0] vel_next;
	logic                    rej;

	logic                    out_valid_q;
	logic signed [VEL_W-1:0] velocity_q;
	logic                    ready_res_q;
	logic                    rejected_q;

	// Configuration is always accepted; indexes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_scale_q    <= VEL_SCALE_RST;
			max_velocity_q <= MAX_VEL_RST;
			ema_alpha_q    <= ALPHA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VEL_SCALE:    vel_scale_q    <= cfg_data[VEL_SCALE_W-1:0];
				REG_MAX_VELOCITY: max_velocity_q <= cfg_data[MAX_VEL_W-1:0];
				REG_EMA_ALPHA:    ema_alpha_q    <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ptr_inc  = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : (ptr_q + 1'b1);

	// Sequencer: with a full window the oldest entry is read at acceptance, and the new sample
	// overwrites it in the next cycle, once the read data has been captured.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ctl      = '0;
		load_out = 1'b0;
		ptr_adv  = 1'b0;
		wr_en    = 1'b0;
		wr_data  = angle_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (full_q) begin
						state_d = ST_DIFF;
					end else begin
						// Filling: store at once, answer with a zero beat.
						wr_en   = 1'b1;
						wr_data = angle_code;
						ptr_adv = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_DIFF: begin
				ctl.ld_diff = 1'b1;
				wr_en       = 1'b1;
				ptr_adv     = 1'b1;
				state_d     = ST_MUL1;
			end
			ST_MUL1: begin
				ctl.ld_mul1 = 1'b1;
				state_d     = ST_SAT;
			end
			ST_SAT: begin
				ctl.ld_sat = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				ctl.ld_mul2 = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					ctl.upd  = !fill_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			full_q  <= 1'b0;
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ptr_adv) begin
				ptr_q <= ptr_inc;
				if (!full_q && (ptr_q == PTR_W'(WINDOW - 1))) begin
					full_q <= 1'b1;
				end
			end
			if (in_acc) begin
				fill_q <= !full_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			angle_q <= angle_code;
		end
	end

	wave_ring #(
		.DEPTH (WINDOW),
		.WIDTH (ANGLE_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ptr_q),
		.wr_data (wr_data),
		.rd_en   (in_acc),
		.rd_addr (ptr_q),
		.rd_data (oldest)
	);

	wave_dp #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.angle        (angle_q),
		.oldest       (oldest),
		.vel_scale    (vel_scale_q),
		.max_velocity (max_velocity_q),
		.ema_alpha    (ema_alpha_q),
		.vel_next     (vel_next),
		.rej          (rej)
	);

	// Result register: holds a finished beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			velocity_q  <= fill_q ? '0 : vel_next;
			ready_res_q <= !fill_q;
			rejected_q  <= !fill_q && rej;
		end
	end

	assign out_valid = out_valid_q;
	assign velocity  = velocity_q;
	assign ready_res = ready_res_q;
	assign rejected  = rejected_q;

endmodule
`default_nettype wire

// ===== sv/wave_checker.sv =====
// Port-level checks for the windowed angle velocity estimator, bound to the top level.
`default_nettype none
module wave_checker #(
	parameter int ANGLE_BITS = 12
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [ANGLE_BITS-1:0]             angle_code,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [wave_pkg::VEL_W-1:0] velocity,
	input wire logic                              ready_res,
	input wire logic                              rejected
);

	// A beat from the filling phase carries a zero velocity and no rejection.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready_res |-> velocity == '0 && !rejected)
		else $error("filling beat carries a non-zero result");

	// Rejection is only possible once a difference has been taken.
	a_rej_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> ready_res)
		else $error("rejected beat without a full window");

	// A stalled result beat stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(velocity) && $stable(ready_res)
		&& $stable(rejected))
		else $error("stalled result beat changed");

	// A stalled input beat keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(angle_code))
		else $error("stalled input beat changed");

endmodule

bind windowed_angle_velocity_estimator wave_checker #(
	.ANGLE_BITS (ANGLE_BITS)
) u_wave_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.angle_code (angle_code),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.velocity   (velocity),
	.ready_res  (ready_res),
	.rejected   (rejected)
);
`default_nettype wire

// ===== bench/velocity_estimate_checker.sv =====
// Checker for the velocity estimator: tracks register and input beats, predicts and compares.
module velocity_estimate_checker #(
	parameter int WINDOW     = 8,
	parameter int ANGLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [ANGLE_BITS-1:0]             angle_code,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [wave_pkg::VEL_W-1:0] velocity,
	input  logic                              ready_res,
	input  logic                              rejected,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [wave_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wave_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                pending_results
);
	import wave_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);
	localparam int FULL_TURN = 1 << ANGLE_BITS;

	typedef struct packed {
		logic signed [VEL_W-1:0] velocity;
		logic                    ready_res;
		logic                    rejected;
	} velocity_beat_t;

	logic [VEL_SCALE_W-1:0]  vel_scale_q;
	logic [MAX_VEL_W-1:0]    max_vel_q;
	logic [ALPHA_W-1:0]      alpha_q;
	logic [ANGLE_BITS-1:0]   angle_hist [WINDOW];
	int                      hist_ptr;
	logic                    hist_full;
	logic signed [VEL_W-1:0] smoothed_vel;
	velocity_beat_t          predicted_velocities [$];
	velocity_beat_t          wanted;
	int                      failures = 0;
	int                      backlog = 0;

	assign fail_count      = failures;
	assign pending_results = backlog;

	// Advances the window and filter by one angle sample and returns the beat it should produce.
	function automatic velocity_beat_t estimate_velocity(logic [ANGLE_BITS-1:0] angle);
		velocity_beat_t        beat;
		logic [ANGLE_BITS-1:0] oldest;
		int                    delta;
		longint                raw;
		int                    magnitude;
		beat = '0;
		oldest = angle_hist[hist_ptr];
		angle_hist[hist_ptr] = angle;
		hist_ptr = (hist_ptr + 1) % WINDOW;
		if (!hist_full) begin
			if (hist_ptr == 0)
				hist_full = 1'b1;
			return beat;
		end
		delta = int'(angle) - int'(oldest);
		if (delta > HALF_TURN)
			delta -= FULL_TURN;
		if (delta < -HALF_TURN)
			delta += FULL_TURN;
		raw = (longint'(delta) * longint'(vel_scale_q) + 64'sd32768) >>> 16;
		if (raw > 32767)
			raw = 32767;
		else if (raw < -32768)
			raw = -32768;
		magnitude = (raw < 0) ? -int'(raw) : int'(raw);
		beat.ready_res = 1'b1;
		if (magnitude > int'(max_vel_q)) begin
			beat.rejected = 1'b1;
		end else begin
			smoothed_vel = smoothed_vel + VEL_W'((longint'(int'(raw) - int'(smoothed_vel))
				* longint'(alpha_q)) >>> 16);
		end
		beat.velocity = smoothed_vel;
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_scale_q  = VEL_SCALE_RST;
			max_vel_q    = MAX_VEL_RST;
			alpha_q      = ALPHA_RST;
			hist_ptr     = 0;
			hist_full    = 1'b0;
			smoothed_vel = '0;
			foreach (angle_hist[i])
				angle_hist[i] = '0;
			predicted_velocities.delete();
			backlog = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VEL_SCALE:    vel_scale_q = cfg_data[VEL_SCALE_W-1:0];
					REG_MAX_VELOCITY: max_vel_q = cfg_data[MAX_VEL_W-1:0];
					REG_EMA_ALPHA:    alpha_q = cfg_data[ALPHA_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predicted_velocities.push_back(estimate_velocity(angle_code));
			if (out_valid && !out_stall) begin
				if (predicted_velocities.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result beat: vel %0d rdy %0b rej %0b",
							velocity, ready_res, rejected);
				end else begin
					wanted = predicted_velocities.pop_front();
					if (velocity !== wanted.velocity || ready_res !== wanted.ready_res
							|| rejected !== wanted.rejected) begin
						failures++;
						if (failures <= 10)
							$display("mismatch exp/act: vel %0d/%0d rdy %0b/%0b rej %0b/%0b",
								wanted.velocity, velocity, wanted.ready_res, ready_res,
								wanted.rejected, rejected);
					end
				end
			end
			backlog = predicted_velocities.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Top-level testbench of the windowed angle velocity estimator: stimulus, receiver stalls and verdict.
module tb;
	import wave_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW     = 8;
	localparam int ANGLE_BITS = 12;
	localparam int FULL_TURN_CODES = 1 << ANGLE_BITS;

	// Spare register index; the block must take the write and change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Settle time after the last result: more than enough for the sequencer to be back in its idle state.
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PHASE_COUNT     = 8;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [ANGLE_BITS-1:0]         angle_code;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [VEL_W-1:0]       velocity;
	logic                          ready_res;
	logic                          rejected;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	int                            fail_count;
	int                            pending_results;

	// Set once by the stimulus to ask the receiver for its long hold-off.
	bit                            hold_req;
	int                            burst_left;
	int unsigned                   cycle_count = 0;

	windowed_angle_velocity_estimator #(
		.WINDOW(WINDOW),
		.ANGLE_BITS(ANGLE_BITS)
	) dut (.*);

	velocity_estimate_checker #(
		.WINDOW(WINDOW),
		.ANGLE_BITS(ANGLE_BITS)
	) velocity_check (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// The run should finish long before this; reaching it means the block has hung.
	initial begin : watchdog
		wait (cycle_count == CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one angle beat and holds it until it is taken. The sender works in bursts:
	// valid stays high from one beat to the next inside a burst, and a random gap (often
	// none at all) follows each burst, so gaps land on every cycle of the block's work.
	task automatic send_angle(input logic [ANGLE_BITS-1:0] angle);
		int gap;
		int pick;
		angle_code <= angle;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			pick = $urandom_range(0, 9);
			gap = (pick < 4) ? 0 : (pick < 8) ? int'($urandom_range(1, 6))
				: int'($urandom_range(7, 30));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Puts one register beat on the configuration channel. Valid is left high so that
	// writes can follow back to back; whoever issues the last write lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_settings(input logic [CFG_DATA_W-1:0] scale,
			input logic [CFG_DATA_W-1:0] limit, input logic [CFG_DATA_W-1:0] weight);
		write_reg(REG_VEL_SCALE, scale);
		write_reg(REG_MAX_VELOCITY, limit);
		write_reg(REG_EMA_ALPHA, weight);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering angles until every predicted result has come back, then lets the
	// sequencer settle so that the registers can be written safely. The count is read on
	// the falling edge, well clear of the checker's update on the rising one.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Simulated shaft motion: segments of constant speed, from creeping to faster than half
	// a turn per window so that the wrap of the difference is exercised both ways. A few
	// beats are lone glitches that leave the trajectory alone, and a few are slips where the
	// position jumps and carries on from there; these provoke the plausibility limit.
	task automatic run_motion(input int count);
		int pos;
		int step;
		int seg;
		int r;
		pos = $urandom_range(0, FULL_TURN_CODES - 1);
		step = 0;
		seg = 0;
		repeat (count) begin
			if (seg == 0) begin
				seg = $urandom_range(8, 60);
				case ($urandom_range(0, 3))
					0: step = int'($urandom_range(0, 16)) - 8;
					1: step = int'($urandom_range(0, 128)) - 64;
					2: step = int'($urandom_range(0, 600)) - 300;
					default: step = int'($urandom_range(0, 1400)) - 700;
				endcase
			end
			seg--;
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_angle(ANGLE_BITS'($urandom));
			end else begin
				if (r < 8)
					pos = $urandom_range(0, FULL_TURN_CODES - 1);
				else
					pos = pos + step + int'($urandom_range(0, 4)) - 2;
				send_angle(pos[ANGLE_BITS-1:0]);
			end
		end
	endtask

	// The receiver stalls on a pattern of its own: stretches with no stalls at all, light
	// and heavy random stalling, and once, on request, one long hold-off during which the
	// sender keeps offering beats so that the result register and the sequencer fill up
	// and the block has to stall its input.
	initial begin : result_stall
		int  mode;
		int  span;
		bit  hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				if (hold_req && !hold_done) begin
					out_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] scale;
		logic [CFG_DATA_W-1:0] limit;
		logic [CFG_DATA_W-1:0] weight;
		arst_n = 1'b0;
		in_valid = 1'b0;
		angle_code = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VEL_SCALE;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = $urandom_range(1, 24);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Window fill with the reset settings. Every one of these eight beats must come
		// back as a zero velocity with ready_res and rejected both low, the last included.
		send_angle(12'd0);
		send_angle(12'd4095);
		send_angle(12'd100);
		send_angle(12'd2049);
		send_angle(12'd2048);
		send_angle(12'd3000);
		send_angle(12'd7);
		send_angle(12'd4000);
		// First computing beats, one against each filled entry in turn. Exactly half a
		// turn keeps its sign in either direction; one code beyond it wraps round.
		send_angle(12'd2048);	// plus half a turn from 0
		send_angle(12'd2047);	// minus half a turn from 4095
		send_angle(12'd2149);	// half a turn and one code forward, wraps negative
		send_angle(12'd0);	// half a turn and one code back, wraps positive
		send_angle(12'd2048);	// no movement
		send_angle(12'd2999);	// one code back
		send_angle(12'd8);	// one code forward
		send_angle(12'd4095);	// small forward step
		drain_results();

		// Largest scale, widest limit and the heaviest weight: the filter lands within a
		// code of each accepted value. A speed saturating at the positive end equals the
		// limit and passes, while the negative end always fails the limit.
		write_settings(24'hFFFFFF, 24'h007FFF, 24'h00FFFF);
		send_angle(12'd0);	// minus half a turn, saturates negative, rejected
		send_angle(12'd4095);	// plus half a turn, saturates positive, accepted
		send_angle(12'd2150);	// one code forward
		send_angle(12'd4095);	// one code back
		send_angle(12'd2048);	// no movement
		drain_results();

		// Rounding ties: with a scale of one half a step of one code lands exactly on a
		// half, which goes up, so plus one code becomes 1 and minus one code becomes 0.
		// A zero limit then rejects anything but zero, and a zero weight freezes the
		// filter. Bits above each register's width are set to show that they are ignored,
		// and the spare index is written as well.
		write_reg(REG_UNUSED, 24'hFFFFFF);
		write_settings(24'h008000, 24'hFF8000, 24'hFF0000);
		send_angle(12'd2999);	// no movement, accepted
		send_angle(12'd9);	// one code forward, rounds up to 1, rejected
		send_angle(12'd4094);	// one code back, rounds up to 0, accepted
		send_angle(12'd2048);	// half a turn forward, rejected
		drain_results();

		// Random motion under a run of settings: the reset values, both extremes, then
		// random ones spread over several orders of magnitude so that the limit sometimes
		// bites and sometimes does not. Every other phase pauses half way until all
		// results are back.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: write_settings(VEL_SCALE_RST, MAX_VEL_RST, ALPHA_RST);
				1: begin
					write_settings(24'hFFFFFF, 24'h007FFF, 24'h00FFFF);
					hold_req = 1'b1;
				end
				2: write_settings(24'h000000, 24'h000000, 24'h000000);
				default: begin
					scale = CFG_DATA_W'($urandom >> $urandom_range(8, 24));
					limit = CFG_DATA_W'(($urandom & 32'h00FF8000)
						| ($urandom_range(0, 32767) >> $urandom_range(0, 12)));
					weight = CFG_DATA_W'(($urandom & 32'h00FF0000) | $urandom_range(0, 65535));
					write_settings(scale, limit, weight);
				end
			endcase
			run_motion(100);
			if (p % 2 == 1)
				drain_results();
			run_motion(100);
			drain_results();
		end

		if (fail_count == 0 && pending_results == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
